>>> rtl/core/tqlu_pkg.sv
`default_nettype none

package tqlu_pkg;

    localparam int NUM_STATES  = 1024;
    localparam int NUM_ACTIONS = 16;

    localparam int STATE_W    = 10;
    localparam int ACT_IN_W   = 4;
    localparam int ACT_OUT_W  = 4;
    localparam int Q_W        = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int SROW_W = $clog2(NUM_STATES);
    localparam int ACT_W  = $clog2(NUM_ACTIONS);
    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_THRESHOLD = 2'd2;

    localparam logic [FRAC_W-1:0] RST_LEARNING_RATE     = 16'd655;
    localparam logic [FRAC_W-1:0] RST_DISCOUNT          = 16'd64881;
    localparam logic [FRAC_W-1:0] RST_EXPLORE_THRESHOLD = 16'd6554;

    typedef struct packed {
        logic [STATE_W-1:0]    cur_state;
        logic [STATE_W-1:0]    nxt_state;
        logic signed [Q_W-1:0] reward;
        logic [FRAC_W-1:0]     random_draw;
        logic [ACT_IN_W-1:0]   random_action;
    } t_in_item;

    typedef struct packed {
        logic [ACT_OUT_W-1:0]  chosen_action;
        logic                  explored;
        logic signed [Q_W-1:0] new_value;
        logic                  saturated;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [FRAC_W-1:0]    reg_data;
    } t_cfg_item;

    // random action reduced into the action range
    function automatic logic [ACT_W-1:0] action_mod(input logic [ACT_IN_W-1:0] a);
        logic [ACT_W-1:0] r;
        r = '0;
        for (int i = 0; i < 2**ACT_IN_W; i++) begin
            if (a == ACT_IN_W'(i)) begin
                r = ACT_W'(i % NUM_ACTIONS);
            end
        end
        return r;
    endfunction

    // state index reduced into the state range by constant long division
    function automatic logic [SROW_W-1:0] state_row(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] v;
        v = s;
        for (int j = STATE_W - 1; j >= 0; j--) begin
            if (32'(v) >= (NUM_STATES << j)) begin
                v = v - STATE_W'(NUM_STATES << j);
            end
        end
        return SROW_W'(v);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tqlu_in_if.sv
`default_nettype none

interface tqlu_in_if;
    logic                valid;
    logic                ready;
    tqlu_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tqlu_out_if.sv
`default_nettype none

interface tqlu_out_if;
    logic                valid;
    logic                ready;
    tqlu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tqlu_cfg_if.sv
`default_nettype none

interface tqlu_cfg_if;
    logic                valid;
    logic                ready;
    tqlu_pkg::t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tabular_q_learning_update_top.sv
// channel   dir  payload                                              transfer
// i_in      in   cur_state, nxt_state, reward, draw, action           valid & ready
// o_out     out  chosen_action, explored, new_value, saturated        valid & ready
// i_cfg     in   reg_index, reg_data (learning rate, discount, eps)   valid & ready
//
// a new input is taken only when idle, once the previous item has been written back; the
// result is registered at write-back, after the two row scans and the update arithmetic
// after reset the memory is cleared one entry a cycle, all NUM_STATES*NUM_ACTIONS entries
// (16384), with i_in held not ready; config writes are taken throughout
// a finished result sits in the output register while the next item is taken;
// write-back waits only if that register still holds an untaken result
`default_nettype none

module tabular_q_learning_update_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tqlu_in_if.sink    i_in,
    tqlu_out_if.source o_out,
    tqlu_cfg_if.sink   i_cfg
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_PREP  = 10'b00_0000_0100,
        S_SCAN  = 10'b00_0000_1000,
        S_DRAIN = 10'b00_0001_0000,
        S_MUL1  = 10'b00_0010_0000,
        S_SUM   = 10'b00_0100_0000,
        S_MUL2  = 10'b00_1000_0000,
        S_RND   = 10'b01_0000_0000,
        S_WB    = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [tqlu_pkg::ADDR_W-1:0]   r_clr;
    logic [tqlu_pkg::FRAC_W-1:0]   r_alpha, r_gamma, r_eps;

    logic [tqlu_pkg::STATE_W-1:0]  r_cur_raw, r_nxt_raw;
    logic [tqlu_pkg::ADDR_W-1:0]   r_cur_base, r_nxt_base;
    logic signed [tqlu_pkg::Q_W-1:0] r_reward;
    logic [tqlu_pkg::ACT_W-1:0]    r_raction;
    logic                          r_explored;

    logic                          r_phase;
    logic [tqlu_pkg::ACT_W-1:0]    r_k;
    logic                          r_rd_vld, r_rd_phase;
    logic [tqlu_pkg::ACT_W-1:0]    r_rd_k;
    logic signed [tqlu_pkg::Q_W-1:0] r_rd_data;
    logic signed [tqlu_pkg::Q_W-1:0] r_best, r_cap, r_maxnext;
    logic [tqlu_pkg::ACT_W-1:0]    r_best_idx;

    logic signed [32:0]            r_gm;
    logic signed [tqlu_pkg::Q_W-1:0] r_q;
    logic [tqlu_pkg::ACT_W-1:0]    r_act;
    logic signed [33:0]            r_d;
    logic [32:0]                   r_pl;
    logic signed [33:0]            r_ph;
    logic signed [18:0]            r_step;

    logic                          r_out_vld;
    tqlu_pkg::t_out_item           r_out;

    logic [tqlu_pkg::Q_W-1:0]      r_mem [tqlu_pkg::DEPTH];

    logic                          w_in_acc, w_cfg_acc, w_out_free, w_out_load;
    logic                          w_scan_last, w_k_last, w_rd_en, w_wr_en;
    logic [tqlu_pkg::ADDR_W-1:0]   w_rd_addr, w_wr_addr;
    logic [tqlu_pkg::Q_W-1:0]      w_wr_data;
    logic signed [33:0]            w_rw, w_gx, w_qx, w_d;
    logic signed [50:0]            w_p;
    logic signed [19:0]            w_nv;
    logic                          w_ovf;
    logic signed [tqlu_pkg::Q_W-1:0] w_new;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_out_vld || o_out.ready;
    assign w_out_load  = (r_state == S_WB) && w_out_free;
    assign w_k_last    = (r_k == tqlu_pkg::ACT_W'(tqlu_pkg::NUM_ACTIONS - 1));
    assign w_scan_last = r_phase && w_k_last;
    assign w_rd_en     = (r_state == S_SCAN);
    assign w_rd_addr   = (r_phase ? r_nxt_base : r_cur_base) + tqlu_pkg::ADDR_W'(r_k);
    assign w_wr_en     = (r_state == S_CLEAR) || w_out_load;
    assign w_wr_addr   = (r_state == S_CLEAR) ? r_clr
                                              : r_cur_base + tqlu_pkg::ADDR_W'(r_act);
    assign w_wr_data   = (r_state == S_CLEAR) ? '0 : w_new;

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // update arithmetic
    always_comb begin
        w_rw  = $signed({{2{r_reward[15]}}, r_reward, 16'h0000});
        w_gx  = $signed({r_gm[32], r_gm});
        w_qx  = $signed({{2{r_q[15]}}, r_q, 16'h0000});
        w_d   = w_rw + w_gx - w_qx;
        w_p   = $signed({r_ph, 17'h00000}) + $signed({18'h00000, r_pl})
              + $signed(51'h0_0000_8000_0000);
        w_nv  = $signed({{4{r_q[15]}}, r_q}) + $signed({r_step[18], r_step});
        w_ovf = (w_nv[19:15] != {5{w_nv[19]}});
        if (w_ovf) begin
            w_new = w_nv[19] ? 16'sh8000 : 16'sh7fff;
        end else begin
            w_new = w_nv[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == tqlu_pkg::ADDR_W'(tqlu_pkg::DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) n_state = S_PREP;
            end
            S_PREP:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_MUL1;
            S_MUL1:  n_state = S_SUM;
            S_SUM:   n_state = S_MUL2;
            S_MUL2:  n_state = S_RND;
            S_RND:   n_state = S_WB;
            S_WB: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_phase   <= 1'b0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + tqlu_pkg::ADDR_W'(1);
            end
            if (r_state == S_PREP) begin
                r_phase <= 1'b0;
                r_k     <= '0;
            end else if (r_state == S_SCAN) begin
                if (w_k_last) begin
                    r_k     <= '0;
                    r_phase <= 1'b1;
                end else begin
                    r_k <= r_k + tqlu_pkg::ACT_W'(1);
                end
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= tqlu_pkg::RST_LEARNING_RATE;
            r_gamma <= tqlu_pkg::RST_DISCOUNT;
            r_eps   <= tqlu_pkg::RST_EXPLORE_THRESHOLD;
        end else if (w_cfg_acc) begin
            case (i_cfg.data.reg_index)
                tqlu_pkg::REG_LEARNING_RATE:     r_alpha <= i_cfg.data.reg_data;
                tqlu_pkg::REG_DISCOUNT:          r_gamma <= i_cfg.data.reg_data;
                tqlu_pkg::REG_EXPLORE_THRESHOLD: r_eps   <= i_cfg.data.reg_data;
                default: ;
            endcase
        end
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= $signed(r_mem[w_rd_addr]);
        end
        r_rd_phase <= r_phase;
        r_rd_k     <= r_k;
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cur_raw  <= i_in.data.cur_state;
            r_nxt_raw  <= i_in.data.nxt_state;
            r_reward   <= i_in.data.reward;
            r_raction  <= tqlu_pkg::action_mod(i_in.data.random_action);
            r_explored <= (i_in.data.random_draw < r_eps);
        end
        if (r_state == S_PREP) begin
            r_cur_base <= tqlu_pkg::ADDR_W'(tqlu_pkg::state_row(r_cur_raw))
                        * tqlu_pkg::ADDR_W'(tqlu_pkg::NUM_ACTIONS);
            r_nxt_base <= tqlu_pkg::ADDR_W'(tqlu_pkg::state_row(r_nxt_raw))
                        * tqlu_pkg::ADDR_W'(tqlu_pkg::NUM_ACTIONS);
        end
        // first greatest and the random action's entry in the current row, maximum of the next row
        if (r_rd_vld) begin
            if (!r_rd_phase) begin
                if (r_rd_k == '0 || r_rd_data > r_best) begin
                    r_best     <= r_rd_data;
                    r_best_idx <= r_rd_k;
                end
                if (r_rd_k == r_raction) begin
                    r_cap <= r_rd_data;
                end
            end else if (r_rd_k == '0 || r_rd_data > r_maxnext) begin
                r_maxnext <= r_rd_data;
            end
        end
        if (r_state == S_MUL1) begin
            r_gm  <= $signed({1'b0, r_gamma}) * r_maxnext;
            r_q   <= r_explored ? r_cap : r_best;
            r_act <= r_explored ? r_raction : r_best_idx;
        end
        if (r_state == S_SUM) begin
            r_d <= w_d;
        end
        if (r_state == S_MUL2) begin
            r_pl <= r_alpha * r_d[16:0];
            r_ph <= $signed({1'b0, r_alpha}) * $signed(r_d[33:17]);
        end
        if (r_state == S_RND) begin
            r_step <= w_p[50:32];
        end
        if (w_out_load) begin
            r_out.chosen_action <= tqlu_pkg::ACT_OUT_W'(r_act);
            r_out.explored      <= r_explored;
            r_out.new_value     <= w_new;
            r_out.saturated     <= w_ovf;
        end
    end

    a_wr_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && r_state != S_CLEAR) |-> w_out_load)
        else $error("table written outside clear or result load");

    a_rd_data_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("read data returned outside the row scan");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR && r_clr == '0))
        else $error("reset did not restart the clearing sweep");

    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (32'(r_act) < tqlu_pkg::NUM_ACTIONS))
        else $error("chosen action out of range");

    a_explore_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_explored) |-> (r_act == r_raction))
        else $error("explored item did not take the random action");

endmodule

`default_nettype wire

>>> verif/tb_tabular_q_learning_update_top.sv
`timescale 1ns / 100ps

module tb_tabular_q_learning_update_top;

    localparam logic [tqlu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tqlu_in_if  in_ch ();
    tqlu_out_if out_ch ();
    tqlu_cfg_if cfg_ch ();

    tabular_q_learning_update_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #4ns i_clk = ~i_clk;

    // model state
    logic signed [tqlu_pkg::Q_W-1:0] q_table [tqlu_pkg::DEPTH];
    logic [tqlu_pkg::FRAC_W-1:0]     alpha_reg;
    logic [tqlu_pkg::FRAC_W-1:0]     gamma_reg;
    logic [tqlu_pkg::FRAC_W-1:0]     eps_reg;

    tqlu_pkg::t_in_item  pending_updates [$];
    tqlu_pkg::t_cfg_item pending_writes [$];
    tqlu_pkg::t_out_item expected_updates [$];

    int items_pushed   = 0;
    int results_seen   = 0;
    int writes_pushed  = 0;
    int writes_taken   = 0;
    int error_count    = 0;
    int explored_seen  = 0;
    int saturated_seen = 0;
    int settings_seen  = 0;
    int send_gap_pct;
    int recv_stall_pct;
    int idle_cycles    = 0;

    logic in_fire;
    logic cfg_fire;

    function automatic tqlu_pkg::t_out_item update_value_table(input tqlu_pkg::t_in_item it);
        int unsigned cur_base;
        int unsigned nxt_base;
        int unsigned act;
        int          i;
        bit          explore;
        bit          sat;
        longint      maxnext;
        longint      q;
        longint      t;
        longint      d;
        longint      p;
        longint      step;
        longint      nv;
        tqlu_pkg::t_out_item r;
        cur_base = (int'(it.cur_state) % tqlu_pkg::NUM_STATES) * tqlu_pkg::NUM_ACTIONS;
        nxt_base = (int'(it.nxt_state) % tqlu_pkg::NUM_STATES) * tqlu_pkg::NUM_ACTIONS;
        explore  = it.random_draw < eps_reg;
        if (explore) begin
            act = int'(it.random_action) % tqlu_pkg::NUM_ACTIONS;
        end else begin
            act = 0;
            for (i = 1; i < tqlu_pkg::NUM_ACTIONS; i++) begin
                if (q_table[cur_base + i] > q_table[cur_base + act]) begin
                    act = i;
                end
            end
        end
        maxnext = q_table[nxt_base];
        for (i = 1; i < tqlu_pkg::NUM_ACTIONS; i++) begin
            if (q_table[nxt_base + i] > maxnext) begin
                maxnext = q_table[nxt_base + i];
            end
        end
        q    = q_table[cur_base + act];
        t    = longint'($signed(it.reward)) * 65536 + longint'(gamma_reg) * maxnext;
        d    = t - q * 65536;
        p    = longint'(alpha_reg) * d;
        step = (p + (longint'(1) <<< 31)) >>> 32;
        nv   = q + step;
        sat  = 1'b0;
        if (nv > 32767) begin
            nv  = 32767;
            sat = 1'b1;
        end else if (nv < -32768) begin
            nv  = -32768;
            sat = 1'b1;
        end
        q_table[cur_base + act] = nv[tqlu_pkg::Q_W-1:0];
        r.chosen_action = act[tqlu_pkg::ACT_OUT_W-1:0];
        r.explored      = explore;
        r.new_value     = nv[tqlu_pkg::Q_W-1:0];
        r.saturated     = sat;
        return r;
    endfunction

    // transfers seen at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire  <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            in_fire  <= in_ch.valid && in_ch.ready;
            cfg_fire <= cfg_ch.valid && cfg_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                expected_updates.push_back(update_value_table(in_ch.data));
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                writes_taken++;
                case (cfg_ch.data.reg_index)
                    tqlu_pkg::REG_LEARNING_RATE:     alpha_reg = cfg_ch.data.reg_data;
                    tqlu_pkg::REG_DISCOUNT:          gamma_reg = cfg_ch.data.reg_data;
                    tqlu_pkg::REG_EXPLORE_THRESHOLD: eps_reg   = cfg_ch.data.reg_data;
                    default: ;
                endcase
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (pending_updates.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_updates.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // register write driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else if (!cfg_ch.valid || cfg_fire) begin
            if (pending_writes.size() > 0) begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.data  <= pending_writes.pop_front();
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        tqlu_pkg::t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_updates.size() == 0) begin
                $error("unexpected result: action %0d value %0d",
                       out_ch.data.chosen_action, $signed(out_ch.data.new_value));
                error_count++;
            end else begin
                want = expected_updates.pop_front();
                explored_seen  += want.explored;
                saturated_seen += want.saturated;
                if (out_ch.data.chosen_action !== want.chosen_action) begin
                    $error("chosen_action: expected %0d, got %0d",
                           want.chosen_action, out_ch.data.chosen_action);
                    error_count++;
                end
                if (out_ch.data.explored !== want.explored) begin
                    $error("explored: expected %0d, got %0d",
                           want.explored, out_ch.data.explored);
                    error_count++;
                end
                if (out_ch.data.new_value !== want.new_value) begin
                    $error("new_value: expected %0d, got %0d",
                           $signed(want.new_value), $signed(out_ch.data.new_value));
                    error_count++;
                end
                if (out_ch.data.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, out_ch.data.saturated);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("tb_tabular_q_learning_update_top: done, errors");
                $finish;
            end
        end
    end

    task automatic push_update(input int cs, input int ns, input int rw, input int dr,
                               input int ra);
        tqlu_pkg::t_in_item it;
        it.cur_state     = cs[tqlu_pkg::STATE_W-1:0];
        it.nxt_state     = ns[tqlu_pkg::STATE_W-1:0];
        it.reward        = rw[tqlu_pkg::Q_W-1:0];
        it.random_draw   = dr[tqlu_pkg::FRAC_W-1:0];
        it.random_action = ra[tqlu_pkg::ACT_IN_W-1:0];
        pending_updates.push_back(it);
        items_pushed++;
    endtask

    task automatic write_reg(input logic [tqlu_pkg::CFG_IDX_W-1:0] idx, input int val);
        tqlu_pkg::t_cfg_item w;
        w.reg_index = idx;
        w.reg_data  = val[tqlu_pkg::FRAC_W-1:0];
        pending_writes.push_back(w);
        writes_pushed++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (results_seen != items_pushed || writes_taken != writes_pushed) begin
            @(negedge i_clk);
        end
    endtask

    // mostly a small set of rows so that values build up, sometimes anywhere
    function automatic int pick_state();
        int sel;
        sel = $urandom_range(0, 7);
        if ($urandom_range(0, 99) < 15) begin
            return $urandom_range(0, 1023);
        end
        return sel[2] ? (1020 + sel[1:0]) : sel[1:0];
    endfunction

    task automatic push_random_update();
        int rw;
        int dr;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       rw = 32767;
            1:       rw = -32768;
            2:       rw = $urandom_range(0, 511) - 256;
            default: rw = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            dr = int'(eps_reg) + $urandom_range(0, 2) - 1;
        end else begin
            dr = $urandom_range(0, 65535);
        end
        push_update(pick_state(), pick_state(), rw, dr, $urandom_range(0, 15));
    endtask

    task automatic run_setting(input int alpha, input int gamma, input int eps,
                               input int count);
        wait_drained();
        write_reg(tqlu_pkg::REG_LEARNING_RATE, alpha);
        write_reg(tqlu_pkg::REG_DISCOUNT, gamma);
        write_reg(tqlu_pkg::REG_EXPLORE_THRESHOLD, eps);
        write_reg(REG_UNUSED, $urandom_range(0, 65535));
        wait_drained();
        settings_seen++;
        // draws on both sides of the threshold
        if (eps > 0) begin
            push_update(pick_state(), pick_state(), $urandom_range(0, 65535), eps - 1,
                        $urandom_range(0, 15));
        end
        push_update(pick_state(), pick_state(), $urandom_range(0, 65535), eps,
                    $urandom_range(0, 15));
        push_update(pick_state(), pick_state(), $urandom_range(0, 65535), 0,
                    $urandom_range(0, 15));
        repeat (count) push_random_update();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        in_fire       = 1'b0;
        cfg_fire      = 1'b0;
        alpha_reg     = tqlu_pkg::RST_LEARNING_RATE;
        gamma_reg     = tqlu_pkg::RST_DISCOUNT;
        eps_reg       = tqlu_pkg::RST_EXPLORE_THRESHOLD;
        foreach (q_table[k]) q_table[k] = '0;
        send_gap_pct   = 12;
        recv_stall_pct = 71;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_seen++;

        // reset settings: empty table, threshold edges, ties, extremes
        push_update(0, 0, 0, 65535, 0);
        push_update(1023, 1023, 32767, 0, 15);
        push_update(1023, 1023, -32768, 0, 0);
        push_update(0, 1023, -32768, 6554, 5);
        push_update(0, 1023, 32767, 6553, 9);
        push_update(2, 5, 32767, 0, 7);
        push_update(2, 5, 32767, 0, 3);
        push_update(2, 5, 0, 65535, 0);
        push_update(3, 5, -32768, 0, 0);
        push_update(3, 5, 0, 65535, 0);
        push_update(682, 341, 21845, 43690, 10);
        push_update(341, 682, -21846, 21845, 5);
        push_update(1023, 2, 256, 65535, 15);
        push_update(1, 1, 32767, 40000, 0);
        push_update(1, 1, 32767, 40000, 0);
        push_update(1, 1, -256, 100, 8);
        run_setting(65535, 65535, 0, 110);
        send_gap_pct   = 71;
        recv_stall_pct = 12;
        run_setting(0, 0, 65535, 100);
        run_setting(32768, 49152, 32768, 110);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_setting($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), 110);
        run_setting(65535, 0, 16384, 77);
        run_setting(tqlu_pkg::RST_LEARNING_RATE, tqlu_pkg::RST_DISCOUNT,
                    tqlu_pkg::RST_EXPLORE_THRESHOLD, 110);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d updates over %0d register settings", items_pushed,
                 settings_seen);
        $display("%0d results explored, %0d saturated", explored_seen, saturated_seen);
        if (error_count == 0 && expected_updates.size() == 0) begin
            $display("tb_tabular_q_learning_update_top: done, clean");
        end else begin
            $display("tb_tabular_q_learning_update_top: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tqlu_pkg.sv
rtl/core/tqlu_in_if.sv
rtl/core/tqlu_out_if.sv
rtl/core/tqlu_cfg_if.sv
rtl/core/tabular_q_learning_update_top.sv
verif/tb_tabular_q_learning_update_top.sv
